// File: sv/u2u_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, the command word passed from front to back, and queue
// sizing.
// ----------------------------------------------------------------------------
package u2u_pkg;

   localparam int UNIT_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int CP_W       = 21;
   localparam int MAX_UNITS_W = 24;
   localparam int COUNT_W    = 25;

   localparam logic [MAX_UNITS_W-1:0] MAX_UNITS_RESET = 24'hFF_FFFF;
   localparam logic [COUNT_W-1:0]     COUNT_MAX       = 25'h1FF_FFFF;

   // Top six bits of a surrogate code unit.
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;
   localparam logic [CP_W-1:0] LIMIT_1B  = 21'h00_007F;
   localparam logic [CP_W-1:0] LIMIT_2B  = 21'h00_07FF;
   localparam logic [CP_W-1:0] LIMIT_3B  = 21'h00_FFFF;

   localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
   localparam logic [BYTE_W-1:0] ERR_BYTE  = 8'h00;

   // Sequence length minus one.
   localparam logic [1:0] LEN_1B = 2'd0;
   localparam logic [1:0] LEN_2B = 2'd1;
   localparam logic [1:0] LEN_3B = 2'd2;
   localparam logic [1:0] LEN_4B = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic [1:0]      len_m1;
      logic            last;
      logic            err;
   } cmd_type;

endpackage

// File: sv/u2u_front.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder front end
// Accepts code units, pairs surrogates, counts units, detects malformed
// strings and issues one command per code point or error.
// ----------------------------------------------------------------------------
module u2u_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [u2u_pkg::UNIT_W-1:0]         code_unit,
   input  logic                               last_unit,
   input  logic                               csr_write_enable,
   input  logic [u2u_pkg::MAX_UNITS_W-1:0]    csr_write_data,
   output logic                               cmd_push,
   output u2u_pkg::cmd_type                   cmd
);

   logic [u2u_pkg::MAX_UNITS_W-1:0] max_units_ff, max_units_in;
   logic [9:0]                      pending_high_ff, pending_high_in;
   logic                            pending_valid_ff, pending_valid_in;
   logic [u2u_pkg::COUNT_W-1:0]     units_seen_ff, units_seen_in;
   logic                            discarding_ff, discarding_in;

   logic [u2u_pkg::COUNT_W-1:0]     count_next;
   logic                            over_limit;
   logic                            is_high;
   logic                            is_low;
   logic [u2u_pkg::CP_W-1:0]        cp;
   logic                            emit_cp;
   logic                            emit_err;

   assign is_high    = (code_unit[15:10] == u2u_pkg::SURR_HIGH_TAG);
   assign is_low     = (code_unit[15:10] == u2u_pkg::SURR_LOW_TAG);
   assign count_next = (units_seen_ff != u2u_pkg::COUNT_MAX) ?
                       units_seen_ff + u2u_pkg::COUNT_W'(1) : units_seen_ff;
   assign over_limit = (count_next > {1'b0, max_units_ff});

   always_comb begin
      max_units_in     = csr_write_enable ? csr_write_data : max_units_ff;
      pending_high_in  = pending_high_ff;
      pending_valid_in = pending_valid_ff;
      units_seen_in    = units_seen_ff;
      discarding_in    = discarding_ff;
      emit_cp          = 1'b0;
      emit_err         = 1'b0;
      cp               = {5'd0, code_unit};

      if (accept) begin
         if (discarding_ff) begin
            if (last_unit) begin
               discarding_in = 1'b0;
               units_seen_in = '0;
            end
         end else begin
            units_seen_in = count_next;
            if (over_limit) begin
               emit_err = 1'b1;
            end else if (pending_valid_ff) begin
               if (!is_low) begin
                  emit_err = 1'b1;
               end else begin
                  cp      = u2u_pkg::SUPP_BASE + {1'b0, pending_high_ff, code_unit[9:0]};
                  emit_cp = 1'b1;
               end
            end else if (is_high) begin
               if (last_unit) begin
                  emit_err = 1'b1;
               end else begin
                  pending_high_in  = code_unit[9:0];
                  pending_valid_in = 1'b1;
               end
            end else if (is_low) begin
               emit_err = 1'b1;
            end else begin
               emit_cp = 1'b1;
            end

            if (emit_cp || emit_err) begin
               pending_high_in  = '0;
               pending_valid_in = 1'b0;
            end
            if (emit_err && !last_unit) begin
               discarding_in = 1'b1;
            end
            // Any unit marked last that is not itself held ends the string.
            if (last_unit && (emit_cp || emit_err)) begin
               units_seen_in = '0;
               discarding_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      cmd.cp   = cp;
      cmd.last = last_unit;
      cmd.err  = emit_err;
      if (cp <= u2u_pkg::LIMIT_1B) begin
         cmd.len_m1 = u2u_pkg::LEN_1B;
      end else if (cp <= u2u_pkg::LIMIT_2B) begin
         cmd.len_m1 = u2u_pkg::LEN_2B;
      end else if (cp <= u2u_pkg::LIMIT_3B) begin
         cmd.len_m1 = u2u_pkg::LEN_3B;
      end else begin
         cmd.len_m1 = u2u_pkg::LEN_4B;
      end
   end

   assign cmd_push = emit_cp || emit_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff     <= u2u_pkg::MAX_UNITS_RESET;
         pending_high_ff  <= '0;
         pending_valid_ff <= 1'b0;
         units_seen_ff    <= '0;
         discarding_ff    <= 1'b0;
      end else begin
         max_units_ff     <= max_units_in;
         pending_high_ff  <= pending_high_in;
         pending_valid_ff <= pending_valid_in;
         units_seen_ff    <= units_seen_in;
         discarding_ff    <= discarding_in;
      end
   end

endmodule

// File: sv/u2u_queue.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder command queue
// Short register queue that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
module u2u_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  u2u_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output u2u_pkg::cmd_type head_cmd
);

   u2u_pkg::cmd_type                  entry_ff [u2u_pkg::QUEUE_DEPTH];
   logic [u2u_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [u2u_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [u2u_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full       = (count_ff == u2u_pkg::QUEUE_CNT_W'(u2u_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + u2u_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + u2u_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + u2u_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - u2u_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/u2u_back.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder back end
// Takes one command at a time and emits its UTF-8 bytes, one word per cycle
// while the output register is free or being popped, through an output register.
// ----------------------------------------------------------------------------
module u2u_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  u2u_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [u2u_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_end_of_string,
   output logic                          rsp_bad_string
);

   u2u_pkg::cmd_type              cur_ff, cur_in;
   logic                          cur_valid_ff, cur_valid_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   logic [u2u_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                          out_eos_ff, out_eos_in;
   logic                          out_bad_ff, out_bad_in;

   logic                          slot_free;
   logic                          emit;
   logic                          final_word;
   logic                          done;
   logic                          load;
   logic [1:0]                    shift;
   logic [5:0]                    cont_bits;
   logic [u2u_pkg::BYTE_W-1:0]    byte_val;

   assign slot_free  = !out_valid_ff || rsp_pop;
   assign emit       = cur_valid_ff && slot_free;
   assign final_word = cur_ff.err || (idx_ff == cur_ff.len_m1);
   assign done       = emit && final_word;
   assign load       = cmd_valid && (!cur_valid_ff || done);
   assign cmd_pop    = load;

   // Continuation bytes take six bits each, highest group first.
   assign shift = cur_ff.len_m1 - idx_ff;

   always_comb begin
      unique case (shift)
         2'd0:    cont_bits = cur_ff.cp[5:0];
         2'd1:    cont_bits = cur_ff.cp[11:6];
         2'd2:    cont_bits = cur_ff.cp[17:12];
         default: cont_bits = {3'd0, cur_ff.cp[20:18]};
      endcase
   end

   always_comb begin
      if (cur_ff.err) begin
         byte_val = u2u_pkg::ERR_BYTE;
      end else if (idx_ff != 2'd0) begin
         byte_val = u2u_pkg::CONT_MARK | {2'd0, cont_bits};
      end else begin
         unique case (cur_ff.len_m1)
            u2u_pkg::LEN_1B: byte_val = {1'b0, cur_ff.cp[6:0]};
            u2u_pkg::LEN_2B: byte_val = u2u_pkg::LEAD_2B | {3'd0, cur_ff.cp[10:6]};
            u2u_pkg::LEN_3B: byte_val = u2u_pkg::LEAD_3B | {4'd0, cur_ff.cp[15:12]};
            default:         byte_val = u2u_pkg::LEAD_4B | {5'd0, cur_ff.cp[20:18]};
         endcase
      end
   end

   // An error word always closes the string for the consumer.
   always_comb begin
      cur_in       = load ? cmd : cur_ff;
      cur_valid_in = load ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      idx_in       = (load || done) ? 2'd0 : (emit ? idx_ff + 2'd1 : idx_ff);
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
      out_byte_in  = emit ? byte_val : out_byte_ff;
      out_eos_in   = emit ? ((cur_ff.last || cur_ff.err) && final_word) : out_eos_ff;
      out_bad_in   = emit ? cur_ff.err : out_bad_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_eos_ff  <= out_eos_in;
      out_bad_ff  <= out_bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_of_string = out_eos_ff;
   assign rsp_bad_string    = out_bad_ff;

endmodule

// File: sv/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, one byte per word.
// ----------------------------------------------------------------------------
// Each pushed word is one UTF-16 code unit, with req_last_unit marking the end
// of a string. Every code point leaves as one to four byte words; the last
// byte of a string carries rsp_end_of_string. A malformed string (unpaired or
// lone surrogate, or more units than csr_write_data last set as the limit)
// ends in one word with rsp_bad_string and rsp_end_of_string set and a zero
// byte; the rest of that string is swallowed and the consumer should drop the
// bytes it already received for it. The front end takes one unit per cycle
// into a four-entry command queue while req_full is low; the back end sends
// one byte per cycle while the consumer pops, so the sustained rate is set by
// the output: ASCII gives one byte, a unit up to 0x7FF two, a basic-plane
// unit above 0x7FF three and a surrogate pair four. Write the limit only while the block is idle.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [u2u_pkg::UNIT_W-1:0]         req_code_unit,
   input  logic                               req_last_unit,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [u2u_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_end_of_string,
   output logic                               rsp_bad_string,
   input  logic                               csr_write_enable,
   input  logic [u2u_pkg::MAX_UNITS_W-1:0]    csr_write_data
);

   logic             accept;
   logic             cmd_push;
   u2u_pkg::cmd_type cmd;
   logic             head_valid;
   u2u_pkg::cmd_type head_cmd;
   logic             head_pop;

   assign accept = req_push && !req_full;

   u2u_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .code_unit        (req_code_unit),
      .last_unit        (req_last_unit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_push         (cmd_push),
      .cmd              (cmd)
   );

   u2u_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   u2u_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (head_valid),
      .cmd               (head_cmd),
      .cmd_pop           (head_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_bad_string    (rsp_bad_string)
   );

endmodule

// File: bench/utf8_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 stream checker
// Watches the code unit and byte channels of the transcoder, predicts the
// UTF-8 words each accepted code unit causes, and compares every word that
// the consumer takes against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   input  logic                                     req_full,
   input  logic [u2u_pkg::UNIT_W-1:0]               req_code_unit,
   input  logic                                     req_last_unit,
   input  logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   input  logic [u2u_pkg::BYTE_W-1:0]               rsp_out_byte,
   input  logic                                     rsp_end_of_string,
   input  logic                                     rsp_bad_string,
   input  logic                                     csr_write_enable,
   input  logic [u2u_pkg::MAX_UNITS_W-1:0]          csr_write_data,
   output int                                       fail_count,
   output int                                       open_count,
   output int                                       words_checked,
   output int                                       strings_rejected
);

   typedef struct packed {
      logic [u2u_pkg::BYTE_W-1:0] data;
      logic                       eos;
      logic                       bad;
   } utf8_word_type;

   utf8_word_type expected_utf8[$];

   logic [u2u_pkg::MAX_UNITS_W-1:0] unit_limit;
   logic [9:0]                      held_high;
   logic                            held_valid;
   logic [u2u_pkg::COUNT_W-1:0]     unit_count;
   logic                            skipping;
   int                              mismatches;
   int                              checked;
   int                              rejected;

   function automatic utf8_word_type make_word(input logic [u2u_pkg::BYTE_W-1:0] data,
                                               input logic eos, input logic bad);
      utf8_word_type w;
      w.data = data;
      w.eos  = eos;
      w.bad  = bad;
      return w;
   endfunction

   task automatic expect_word(input logic [u2u_pkg::BYTE_W-1:0] data,
                              input logic eos, input logic bad);
      utf8_word_type w;
      w = make_word(data, eos, bad);
      expected_utf8 = {expected_utf8, w};
   endtask

   // The error word ends the string for the consumer; any units that follow
   // up to the one marked last are swallowed.
   task automatic reject_string();
      expect_word(u2u_pkg::ERR_BYTE, 1'b1, 1'b1);
      held_high  = '0;
      held_valid = 1'b0;
      skipping   = 1'b1;
      rejected++;
   endtask

   task automatic encode_code_point(input logic [u2u_pkg::CP_W-1:0] cp, input logic last);
      logic [u2u_pkg::BYTE_W-1:0] seq [0:3];
      int                         n;
      int                         k;
      if (cp <= u2u_pkg::LIMIT_1B) begin
         seq[0] = cp[7:0];
         n = 1;
      end else if (cp <= u2u_pkg::LIMIT_2B) begin
         seq[0] = u2u_pkg::LEAD_2B | {3'b000, cp[10:6]};
         seq[1] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
         n = 2;
      end else if (cp <= u2u_pkg::LIMIT_3B) begin
         seq[0] = u2u_pkg::LEAD_3B | {4'b0000, cp[15:12]};
         seq[1] = u2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
         seq[2] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
         n = 3;
      end else begin
         seq[0] = u2u_pkg::LEAD_4B | {5'b00000, cp[20:18]};
         seq[1] = u2u_pkg::CONT_MARK | {2'b00, cp[17:12]};
         seq[2] = u2u_pkg::CONT_MARK | {2'b00, cp[11:6]};
         seq[3] = u2u_pkg::CONT_MARK | {2'b00, cp[5:0]};
         n = 4;
      end
      for (k = 0; k < n; k++)
         expect_word(seq[k], last && (k == n - 1), 1'b0);
   endtask

   task automatic predict_unit(input logic [u2u_pkg::UNIT_W-1:0] unit, input logic last);
      logic [u2u_pkg::CP_W-1:0] cp;
      if (!skipping) begin
         if (unit_count != u2u_pkg::COUNT_MAX)
            unit_count = unit_count + u2u_pkg::COUNT_W'(1);
         if (unit_count > {1'b0, unit_limit}) begin
            reject_string();
         end else if (held_valid) begin
            if (unit[15:10] != u2u_pkg::SURR_LOW_TAG) begin
               reject_string();
            end else begin
               cp = u2u_pkg::SUPP_BASE + {1'b0, held_high, unit[9:0]};
               held_high  = '0;
               held_valid = 1'b0;
               encode_code_point(cp, last);
            end
         end else if (unit[15:10] == u2u_pkg::SURR_HIGH_TAG) begin
            if (last) begin
               reject_string();
            end else begin
               held_high  = unit[9:0];
               held_valid = 1'b1;
            end
         end else if (unit[15:10] == u2u_pkg::SURR_LOW_TAG) begin
            reject_string();
         end else begin
            encode_code_point({5'b00000, unit}, last);
         end
      end
      // Whatever happened, the unit marked last starts a fresh string.
      if (last) begin
         held_high  = '0;
         held_valid = 1'b0;
         unit_count = '0;
         skipping   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      utf8_word_type want;
      if (reset) begin
         expected_utf8.delete();
         unit_limit = u2u_pkg::MAX_UNITS_RESET;
         held_high  = '0;
         held_valid = 1'b0;
         unit_count = '0;
         skipping   = 1'b0;
         mismatches = 0;
         checked    = 0;
         rejected   = 0;
      end else begin
         if (csr_write_enable)
            unit_limit = csr_write_data;
         if (rsp_pop && !rsp_empty) begin
            checked++;
            if (expected_utf8.size() == 0) begin
               if (mismatches < 10)
                  $display("Unexpected word: byte %02h eos %0b bad %0b",
                           rsp_out_byte, rsp_end_of_string, rsp_bad_string);
               mismatches++;
            end else begin
               want = expected_utf8.pop_front();
               if (rsp_out_byte !== want.data || rsp_end_of_string !== want.eos ||
                   rsp_bad_string !== want.bad) begin
                  if (mismatches < 10) begin
                     $display("Word %0d mismatch: expected byte %02h eos %0b bad %0b",
                              checked, want.data, want.eos, want.bad);
                     $display("   actual byte %02h eos %0b bad %0b",
                              rsp_out_byte, rsp_end_of_string, rsp_bad_string);
                  end
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full)
            predict_unit(req_code_unit, req_last_unit);
      end
      fail_count       <= mismatches;
      open_count       <= expected_utf8.size();
      words_checked    <= checked;
      strings_rejected <= rejected;
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transcoder testbench
// Feeds directed and random UTF-16 strings through the transcoder under
// several unit limits, with random gaps on both channels, one long consumer
// stall and a final stretch at full speed; a checker instance scores every word.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_CYCLES = 16;
   localparam int LONG_HOLD    = 300;

   logic                            clock;
   logic                            reset;
   logic                            req_push;
   logic                            req_full;
   logic [u2u_pkg::UNIT_W-1:0]      req_code_unit;
   logic                            req_last_unit;
   logic                            rsp_empty;
   logic                            rsp_pop;
   logic [u2u_pkg::BYTE_W-1:0]      rsp_out_byte;
   logic                            rsp_end_of_string;
   logic                            rsp_bad_string;
   logic                            csr_write_enable;
   logic [u2u_pkg::MAX_UNITS_W-1:0] csr_write_data;

   int fail_count;
   int open_count;
   int words_checked;
   int strings_rejected;
   int cycle_count = 0;
   int full_stalls = 0;
   int units_sent  = 0;
   int strings_sent = 0;

   bit tx_bursty;
   bit rx_bursty;
   bit hold_request;
   bit hold_served;

   logic [u2u_pkg::UNIT_W-1:0] text_buf[$];

   utf16_to_utf8_transcoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code_unit     (req_code_unit),
      .req_last_unit     (req_last_unit),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_bad_string    (rsp_bad_string),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   utf8_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_code_unit     (req_code_unit),
      .req_last_unit     (req_last_unit),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_bad_string    (rsp_bad_string),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .open_count        (open_count),
      .words_checked     (words_checked),
      .strings_rejected  (strings_rejected)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_push && req_full)
         full_stalls <= full_stalls + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, open_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Consumer side: pops freely, in random bursts of idling, or holds off
   // once for a long stretch so the block backs up into its input.
   initial begin
      rsp_pop     = 1'b0;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served <= 1'b1;
         end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 16)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic append_unit(input logic [u2u_pkg::UNIT_W-1:0] unit);
      text_buf = {text_buf, unit};
   endtask

   // All stimulus tasks are entered and left right after a rising edge.
   task automatic send_text();
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         if (tx_bursty && $urandom_range(0, 4) == 0) begin
            req_push      <= 1'b0;
            req_code_unit <= u2u_pkg::UNIT_W'($urandom);
            req_last_unit <= 1'($urandom);
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         req_push      <= 1'b1;
         req_code_unit <= text_buf[i];
         req_last_unit <= (i == text_buf.size() - 1);
         do @(posedge clock); while (req_full);
         units_sent++;
      end
      strings_sent++;
   endtask

   // Held high surrogates and swallowed units give no word, so a quiet stretch
   // follows the last expected word before the block counts as idle.
   task automatic await_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [u2u_pkg::MAX_UNITS_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed strings with random content, with some lone and
   // mispaired surrogates and raw random units mixed in.
   task automatic run_random_phase(input int unit_budget, input int max_len);
      int                         first;
      int                         len;
      int                         pick;
      logic [u2u_pkg::UNIT_W-1:0] unit;
      logic [9:0]                 payload;
      first = units_sent;
      while (units_sent - first < unit_budget) begin
         text_buf.delete();
         len = $urandom_range(1, max_len);
         while (text_buf.size() < len) begin
            pick    = $urandom_range(0, 99);
            payload = 10'($urandom);
            if (pick < 20) begin
               append_unit(u2u_pkg::UNIT_W'($urandom_range(0, 'h7F)));
            end else if (pick < 35) begin
               append_unit(u2u_pkg::UNIT_W'($urandom_range('h80, 'h7FF)));
            end else if (pick < 55) begin
               unit = u2u_pkg::UNIT_W'($urandom_range('h800, 'hFFFF));
               // Move surrogate values up into the range 0xF800 to 0xFFFF.
               if (unit[15:11] == 5'b11011)
                  unit = unit ^ 16'h2000;
               append_unit(unit);
            end else if (pick < 88) begin
               append_unit({u2u_pkg::SURR_HIGH_TAG, payload});
               append_unit({u2u_pkg::SURR_LOW_TAG, 10'($urandom)});
            end else if (pick < 92) begin
               append_unit({u2u_pkg::SURR_LOW_TAG, payload});
            end else if (pick < 96) begin
               append_unit({u2u_pkg::SURR_HIGH_TAG, payload});
            end else begin
               append_unit(u2u_pkg::UNIT_W'($urandom));
            end
         end
         send_text();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_push         = 1'b0;
      req_code_unit    = '0;
      req_last_unit    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      tx_bursty        = 1'b1;
      rx_bursty        = 1'b1;
      hold_request     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_limit(u2u_pkg::MAX_UNITS_RESET);
      text_buf = {16'h0000};
      send_text();
      // Boundaries of the one, two and three byte forms.
      text_buf = {16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
      send_text();
      // Lowest and highest supplementary code points.
      text_buf = {16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF};
      send_text();
      // Lone low surrogate mid-string; the rest is swallowed.
      text_buf = {16'h0041, 16'hDC00, 16'h0042, 16'h0043};
      send_text();
      // High surrogate followed by a unit that is not a low surrogate.
      text_buf = {16'hD800, 16'h0041};
      send_text();
      text_buf = {16'hDBFF, 16'hD800, 16'h0030};
      send_text();
      // Unpaired high surrogate as the last unit, lone low as the last unit.
      text_buf = {16'hDBFF};
      send_text();
      text_buf = {16'hDFFF};
      send_text();

      // Unit count limits, including one that lands on a pending pair.
      await_idle();
      write_limit('0);
      text_buf = {16'h0041};
      send_text();
      await_idle();
      write_limit(24'd1);
      text_buf = {16'h0041, 16'h0042, 16'h0043};
      send_text();
      await_idle();
      write_limit(24'd2);
      text_buf = {16'h0041, 16'hD800, 16'hDC00};
      send_text();

      // Long consumer stall while the producer keeps pushing.
      await_idle();
      write_limit(u2u_pkg::MAX_UNITS_RESET);
      tx_bursty = 1'b0;
      hold_request <= 1'b1;
      run_random_phase(25, 10);

      await_idle();
      write_limit(u2u_pkg::MAX_UNITS_W'($urandom_range(1, 6)));
      tx_bursty = 1'b1;
      run_random_phase(20, 8);

      await_idle();
      write_limit('0);
      run_random_phase(6, 3);

      // Final stretch at full speed on both sides.
      await_idle();
      tx_bursty = 1'b0;
      rx_bursty <= 1'b0;
      write_limit(u2u_pkg::MAX_UNITS_W'($urandom_range(3, 8)));
      run_random_phase(15, 8);
      await_idle();

      $display("Sent %0d code units in %0d strings under a range of unit limits",
               units_sent, strings_sent);
      $display("Checked %0d UTF-8 words, %0d strings rejected, input held off %0d cycles",
               words_checked, strings_rejected, full_stalls);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
